FILE: hdl/tkws_pkg.sv
package tkws_pkg;

  // Field widths
  localparam int JOINT_W  = 8;
  localparam int WEIGHT_W = 16;
  localparam int KC_W     = 3;

  // Default store depth and register reset value
  localparam int            MAX_KEEP_DEF = 4;
  localparam logic [KC_W-1:0] KEEP_RESET = 3'd4;

  // One kept weight
  typedef struct packed {
    logic [JOINT_W-1:0]  joint;
    logic [JOINT_W-1:0]  local_joint;
    logic [WEIGHT_W-1:0] weight;
  } entry_t;

  // Store cell control
  typedef struct packed {
    logic load;   // take the incoming request
    logic shift;  // take the right neighbor's entry
  } cell_ctrl_t;

  // Output cell contents
  typedef struct packed {
    logic   valid;
    logic   last;
    entry_t ent;
  } out_slot_t;

  // Output cell control
  typedef struct packed {
    logic load;     // copy the finished vertex
    logic advance;  // head taken, move one toward the port
  } out_ctrl_t;

endpackage

FILE: hdl/tkws_cell.sv
module tkws_cell (
  input  logic                clk,
  input  tkws_pkg::cell_ctrl_t ctrl,
  input  tkws_pkg::entry_t    new_ent,
  input  tkws_pkg::entry_t    right_ent,
  output tkws_pkg::entry_t    ent_r,
  output tkws_pkg::entry_t    ent_nxt
);
  import tkws_pkg::*;

  // Load wins over shift: the append slot sits after the gap closes
  always_comb begin
    if (ctrl.load) begin
      ent_nxt = new_ent;
    end else if (ctrl.shift) begin
      ent_nxt = right_ent;
    end else begin
      ent_nxt = ent_r;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

FILE: hdl/tkws_out_cell.sv
module tkws_out_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tkws_pkg::out_ctrl_t    ctrl,
  input  tkws_pkg::out_slot_t    load_slot,
  input  tkws_pkg::out_slot_t    right_slot,
  output tkws_pkg::out_slot_t    slot_r
);
  import tkws_pkg::*;

  out_slot_t slot_nxt;

  // Parallel load from the store, or shift toward the output port
  always_comb begin
    if (ctrl.load) begin
      slot_nxt = load_slot;
    end else if (ctrl.advance) begin
      slot_nxt = right_slot;
    end else begin
      slot_nxt = slot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.valid <= 1'b0;
    end else begin
      slot_r.valid <= slot_nxt.valid;
    end
    slot_r.last <= slot_nxt.last;
    slot_r.ent  <= slot_nxt.ent;
  end

endmodule

FILE: hdl/top_k_weight_selector.sv
// Keeps the keep_count largest joint weights of a vertex (1..MAX_KEEP, zero
// acts as 1, larger values saturate) in a row of cells in arrival order. One
// weight request is taken every clock. Below the limit it is appended; at the
// limit it is compared against all kept weights at once, dropped if strictly
// below every one, else the earliest smallest entry is removed by shifting its
// right neighbors down one cell and the new weight appended. On the
// end-of-vertex request the kept entries are copied into a second row of
// output cells and the store is cleared in the same cycle, so the next
// vertex can start at once. The output row drains one entry per cycle unless
// stalled, last_kept on the final one. An end-of-vertex request is stalled
// while the output row holds entries of the previous vertex, unless the only
// one left is taken in that same cycle; other requests are never stalled.
module top_k_weight_selector #(
  parameter int MAX_KEEP = tkws_pkg::MAX_KEEP_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tkws_pkg::KC_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tkws_pkg::JOINT_W-1:0]  in_joint_id,
  input  logic [tkws_pkg::JOINT_W-1:0]  in_local_joint_id,
  input  logic [tkws_pkg::WEIGHT_W-1:0] in_weight_value,
  input  logic                          in_end_of_vertex,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tkws_pkg::JOINT_W-1:0]  out_kept_joint_id,
  output logic [tkws_pkg::JOINT_W-1:0]  out_kept_local_joint_id,
  output logic [tkws_pkg::WEIGHT_W-1:0] out_kept_weight,
  output logic                          out_last_kept
);
  import tkws_pkg::*;

  localparam int CW   = $clog2(MAX_KEEP + 1);
  localparam int CMPW = (CW > KC_W) ? CW : KC_W;

  logic [KC_W-1:0] keep_count_r;
  logic [CW-1:0]   total_r, total_nxt, total_upd, total_m1;

  entry_t     new_ent;
  entry_t     ent_q   [MAX_KEEP];
  entry_t     ent_nxt [MAX_KEEP];
  cell_ctrl_t cctrl   [MAX_KEEP];
  out_slot_t  oslot_q [MAX_KEEP];
  out_slot_t  oload   [MAX_KEEP];
  out_ctrl_t  octrl   [MAX_KEEP];

  logic [MAX_KEEP-1:0] valid_vec, is_min, out_valid_vec, out_last_vec;
  logic [WEIGHT_W-1:0] min_w;
  logic [CMPW-1:0]     limit, kc_ext;
  logic                in_acc, out_acc, full, drop, remove, append;
  logic                head_only, row_free;

  // Output row status
  always_comb begin
    for (int i = 0; i < MAX_KEEP; i++) begin
      out_valid_vec[i] = oslot_q[i].valid;
      out_last_vec[i]  = oslot_q[i].last;
    end
  end

  assign head_only = (out_valid_vec & ~MAX_KEEP'(1)) == '0;

  // Handshakes: the output row may reload when its last entry leaves
  assign out_acc  = oslot_q[0].valid && !out_stall;
  assign row_free = !oslot_q[0].valid || (out_acc && head_only);
  assign in_stall = in_end_of_vertex && !row_free;
  assign in_acc   = in_valid && !in_stall;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_count_r <= KEEP_RESET;
    end else if (cfg_we) begin
      keep_count_r <= cfg_wdata;
    end
  end

  // Effective limit, clamped to 1..MAX_KEEP
  always_comb begin
    kc_ext = CMPW'(keep_count_r);
    if (kc_ext == '0) begin
      limit = CMPW'(1);
    end else if (kc_ext > CMPW'(MAX_KEEP)) begin
      limit = CMPW'(MAX_KEEP);
    end else begin
      limit = kc_ext;
    end
  end

  assign new_ent = '{joint: in_joint_id, local_joint: in_local_joint_id,
                     weight: in_weight_value};

  // Earliest minimum: all pairwise compares in parallel
  always_comb begin
    for (int i = 0; i < MAX_KEEP; i++) begin
      valid_vec[i] = CW'(i) < total_r;
    end
    min_w = '0;
    for (int i = 0; i < MAX_KEEP; i++) begin
      is_min[i] = valid_vec[i];
      for (int j = 0; j < MAX_KEEP; j++) begin
        if (j < i && valid_vec[j] && !(ent_q[i].weight < ent_q[j].weight)) begin
          is_min[i] = 1'b0;
        end
        if (j > i && valid_vec[j] && (ent_q[i].weight > ent_q[j].weight)) begin
          is_min[i] = 1'b0;
        end
      end
      if (is_min[i]) begin
        min_w = min_w | ent_q[i].weight;
      end
    end
  end

  // Insert decision
  assign full   = CMPW'(total_r) >= limit;
  assign drop   = full && (in_weight_value < min_w);
  assign remove = full && !drop;
  assign append = !full;
  assign total_m1 = total_r - CW'(1);

  always_comb begin
    if (append) begin
      total_upd = total_r + CW'(1);
    end else begin
      total_upd = total_r;
    end
    total_nxt = total_r;
    if (in_acc) begin
      total_nxt = in_end_of_vertex ? '0 : total_upd;
    end
  end

  // Store cell control: shift from the removed slot onward, load at the tail
  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int i = 0; i < MAX_KEEP; i++) begin
      seen = seen | is_min[i];
      cctrl[i].shift = in_acc && remove && seen;
      cctrl[i].load  = in_acc && ((remove && CW'(i) == total_m1) ||
                                  (append && CW'(i) == total_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else begin
      total_r <= total_nxt;
    end
  end

  // Output cell control and load values from the updated store
  always_comb begin
    for (int i = 0; i < MAX_KEEP; i++) begin
      oload[i].valid   = CW'(i) < total_upd;
      oload[i].last    = total_upd == CW'(i + 1);
      oload[i].ent     = ent_nxt[i];
      octrl[i].load    = in_acc && in_end_of_vertex;
      octrl[i].advance = out_acc;
    end
  end

  for (genvar g = 0; g < MAX_KEEP; g++) begin : g_cell
    if (g == MAX_KEEP - 1) begin : g_tail
      tkws_cell u_cell (
        .clk       (clk),
        .ctrl      (cctrl[g]),
        .new_ent   (new_ent),
        .right_ent (ent_q[g]),
        .ent_r     (ent_q[g]),
        .ent_nxt   (ent_nxt[g])
      );
      tkws_out_cell u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (octrl[g]),
        .load_slot  (oload[g]),
        .right_slot ('0),
        .slot_r     (oslot_q[g])
      );
    end else begin : g_body
      tkws_cell u_cell (
        .clk       (clk),
        .ctrl      (cctrl[g]),
        .new_ent   (new_ent),
        .right_ent (ent_q[g+1]),
        .ent_r     (ent_q[g]),
        .ent_nxt   (ent_nxt[g])
      );
      tkws_out_cell u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (octrl[g]),
        .load_slot  (oload[g]),
        .right_slot (oslot_q[g+1]),
        .slot_r     (oslot_q[g])
      );
    end
  end

  // Output port from the head cell
  assign out_valid               = oslot_q[0].valid;
  assign out_kept_joint_id       = oslot_q[0].ent.joint;
  assign out_kept_local_joint_id = oslot_q[0].ent.local_joint;
  assign out_kept_weight         = oslot_q[0].ent.weight;
  assign out_last_kept           = oslot_q[0].last;

  // Checks
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMPW'(total_r) <= CMPW'(MAX_KEEP))
    else $error("kept count above store depth");

  a_one_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones(out_valid_vec & out_last_vec) == 1)
    else $error("pending vertex must hold exactly one last entry");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_end_of_vertex |=> total_r == '0 && out_valid)
    else $error("end of vertex must clear store and start output");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_end_of_vertex && append |=> total_r == $past(total_r) + CW'(1))
    else $error("append did not grow the store");

  a_min_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> $onehot(is_min))
    else $error("full store must have exactly one eviction candidate");

endmodule
